>>> rtl/core/quaternion_vector_rotate_defines.svh
// Assertion macros shared by the quaternion rotate checker.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define QVR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/qvr_pkg.sv
// Types and constants for the quaternion vector rotate pipeline.
package qvr_pkg;

    localparam int FW   = 16;   // field width
    localparam int PW   = 32;   // q*v product width
    localparam int TW   = 34;   // t component width
    localparam int NW   = 34;   // |q|^2 width
    localparam int MW   = 50;   // t*q product width
    localparam int RW   = 52;   // numerator / remainder width
    localparam int QW   = 17;   // quotient bits produced by the divider
    localparam int NSTG = 6;    // stages in front of the divider
    localparam int NPIP = NSTG + QW + 1;

    localparam logic [QW-1:0] POS_LIM = QW'(32767);
    localparam logic [QW-1:0] NEG_LIM = QW'(32768);

    typedef struct packed {
        logic [2:0][RW-1:0] rem;
        logic [2:0][QW-1:0] quo;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic [RW-1:0]      dsh;
        logic               degen;
    } div_word_t;

endpackage

>>> rtl/core/quaternion_vector_rotate.sv
// Top level: rotate a 3-vector by a Q1.14 quaternion, fully pipelined.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata; each word carries the
//   quaternion (w,x,y,z, signed Q1.14) and the vector (x,y,z, signed ints).
//   Result words leave on m_tvalid/m_tready/m_tdata/m_tuser: the rotated
//   vector, rounded to nearest (ties away from zero) and clamped to 16 bits,
//   plus a saturated flag and a degenerate flag (all-zero quaternion, which
//   forces a zero result).
// Structure: the word passes 24 register stages: six of multiply, sum and
//   divider setup, 17 of restoring division (one quotient bit per stage),
//   one of clamp and output register.
// Throughput: one word per cycle, sustained while m_tready is high.
// Reset: rst_n clears every stage valid bit; the data path is not reset.
// Stall: when m_tready is low the output word holds; each stage with a
//   valid word waits while stages behind an empty slot keep filling, so
//   bubbles collapse and s_tready drops only when the whole pipe is full.
module quaternion_vector_rotate (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48],
    // vec_x[79:64], vec_y[95:80], vec_z[111:96]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_x[15:0], rot_y[31:16], rot_z[47:32]
    output logic [47:0]  m_tdata,
    // saturated[0], degenerate[1]
    output logic [1:0]   m_tuser
);
    import qvr_pkg::*;

    logic [NPIP-1:0] v_reg;
    logic [NPIP-1:0] en;

    // Stage enables: a stage loads when it is empty or its successor loads.
    always_comb
    begin
        en[NPIP-1] = !v_reg[NPIP-1] || m_tready;
        for (int k = NPIP - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NPIP; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Unpack the input word.
    logic signed [FW-1:0] qw, qx, qy, qz, vx, vy, vz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];
    assign vx = s_tdata[79:64];
    assign vy = s_tdata[95:80];
    assign vz = s_tdata[111:96];

    // Stage 0: q*v cross terms and squares.
    logic signed [PW-1:0] p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_zy_reg;
    logic signed [PW-1:0] p_wy_reg, p_xz_reg, p_zx_reg;
    logic signed [PW-1:0] p_wz_reg, p_xy_reg, p_yx_reg;
    logic signed [PW-1:0] s_w_reg, s_x_reg, s_y_reg, s_z_reg;
    logic signed [FW-1:0] q0w_reg, q0x_reg, q0y_reg, q0z_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_xx_reg <= qx * vx;
            p_yy_reg <= qy * vy;
            p_zz_reg <= qz * vz;
            p_wx_reg <= qw * vx;
            p_yz_reg <= qy * vz;
            p_zy_reg <= qz * vy;
            p_wy_reg <= qw * vy;
            p_xz_reg <= qx * vz;
            p_zx_reg <= qz * vx;
            p_wz_reg <= qw * vz;
            p_xy_reg <= qx * vy;
            p_yx_reg <= qy * vx;
            s_w_reg  <= qw * qw;
            s_x_reg  <= qx * qx;
            s_y_reg  <= qy * qy;
            s_z_reg  <= qz * qz;
            q0w_reg  <= qw;
            q0x_reg  <= qx;
            q0y_reg  <= qy;
            q0z_reg  <= qz;
        end
    end

    // Stage 1: t = q * (0,v) and |q|^2.
    logic signed [TW-1:0] tw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [NW-1:0] n1_reg;
    logic signed [FW-1:0] q1w_reg, q1x_reg, q1y_reg, q1z_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tw_reg  <= TW'(-(TW'(p_xx_reg) + TW'(p_yy_reg) + TW'(p_zz_reg)));
            tx_reg  <= TW'(p_wx_reg) + TW'(p_yz_reg) - TW'(p_zy_reg);
            ty_reg  <= TW'(p_wy_reg) - TW'(p_xz_reg) + TW'(p_zx_reg);
            tz_reg  <= TW'(p_wz_reg) + TW'(p_xy_reg) - TW'(p_yx_reg);
            n1_reg  <= NW'(s_w_reg) + NW'(s_x_reg) + NW'(s_y_reg) + NW'(s_z_reg);
            q1w_reg <= q0w_reg;
            q1x_reg <= q0x_reg;
            q1y_reg <= q0y_reg;
            q1z_reg <= q0z_reg;
        end
    end

    // Stage 2: products of t with the conjugate.
    logic signed [MW-1:0] m_wx_reg, m_xw_reg, m_yz_reg, m_zy_reg;
    logic signed [MW-1:0] m_wy_reg, m_xz_reg, m_yw_reg, m_zx_reg;
    logic signed [MW-1:0] m_wz_reg, m_xy_reg, m_yx_reg, m_zw_reg;
    logic signed [NW-1:0] n2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            m_wx_reg <= tw_reg * q1x_reg;
            m_xw_reg <= tx_reg * q1w_reg;
            m_yz_reg <= ty_reg * q1z_reg;
            m_zy_reg <= tz_reg * q1y_reg;
            m_wy_reg <= tw_reg * q1y_reg;
            m_xz_reg <= tx_reg * q1z_reg;
            m_yw_reg <= ty_reg * q1w_reg;
            m_zx_reg <= tz_reg * q1x_reg;
            m_wz_reg <= tw_reg * q1z_reg;
            m_xy_reg <= tx_reg * q1y_reg;
            m_yx_reg <= ty_reg * q1x_reg;
            m_zw_reg <= tz_reg * q1w_reg;
            n2_reg   <= n1_reg;
        end
    end

    // Stage 3: vector part of t * conj(q).
    logic signed [RW-1:0] r_reg [3];
    logic signed [NW-1:0] n3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            r_reg[0] <= RW'(m_xw_reg) - RW'(m_wx_reg) - RW'(m_yz_reg) + RW'(m_zy_reg);
            r_reg[1] <= RW'(m_xz_reg) - RW'(m_wy_reg) + RW'(m_yw_reg) - RW'(m_zx_reg);
            r_reg[2] <= RW'(m_yx_reg) - RW'(m_wz_reg) - RW'(m_xy_reg) + RW'(m_zw_reg);
            n3_reg   <= n2_reg;
        end
    end

    // Stage 4: magnitude with the rounding offset, N = 2|r| + n, D = 2n.
    logic [RW-1:0] num_reg [3];
    logic [2:0]    neg4_reg;
    logic [RW-1:0] den_reg;
    logic          degen4_reg;
    logic [RW-1:0] rabs [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rabs[c] = r_reg[c][RW-1] ? RW'(-r_reg[c]) : RW'(r_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c]  <= (rabs[c] << 1) + RW'(unsigned'(n3_reg));
                neg4_reg[c] <= r_reg[c][RW-1];
            end
            den_reg    <= RW'(unsigned'(n3_reg)) << 1;
            degen4_reg <= (n3_reg == '0);
        end
    end

    // Stage 5: flag quotients that cannot fit the divider, seed the divider.
    div_word_t div_w [QW+1];
    div_word_t div0_reg;
    div_word_t div0_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            div0_next.rem[c] = num_reg[c];
            div0_next.quo[c] = '0;
            div0_next.neg[c] = neg4_reg[c];
            div0_next.ovf[c] = num_reg[c] >= (den_reg << QW);
        end
        div0_next.dsh   = den_reg << (QW - 1);
        div0_next.degen = degen4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            div0_reg <= div0_next;
        end
    end

    assign div_w[0] = div0_reg;

    // Divider: one quotient bit per stage.
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        qvr_div_stage u_div (
            .clk  (clk),
            .en   (en[NSTG+i]),
            .din  (div_w[i]),
            .dout (div_w[i+1])
        );
    end

    // Final stage: clamp, apply sign, override on degenerate quaternion.
    div_word_t            dq;
    logic [2:0][FW-1:0]   rot_next;
    logic [2:0]           sat_c;
    logic [47:0]          odata_reg;
    logic [1:0]           ouser_reg;

    assign dq = div_w[QW];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sat_c[c]    = 1'b0;
            rot_next[c] = '0;
            if (!dq.neg[c])
            begin
                if (dq.ovf[c] || dq.quo[c] > POS_LIM)
                begin
                    rot_next[c] = POS_LIM[FW-1:0];
                    sat_c[c]    = 1'b1;
                end
                else
                begin
                    rot_next[c] = dq.quo[c][FW-1:0];
                end
            end
            else
            begin
                if (dq.ovf[c] || dq.quo[c] > NEG_LIM)
                begin
                    rot_next[c] = NEG_LIM[FW-1:0];
                    sat_c[c]    = 1'b1;
                end
                else
                begin
                    rot_next[c] = FW'(~dq.quo[c][FW-1:0] + FW'(1));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NPIP-1])
        begin
            if (dq.degen)
            begin
                odata_reg <= '0;
                ouser_reg <= 2'b10;
            end
            else
            begin
                odata_reg <= {rot_next[2], rot_next[1], rot_next[0]};
                ouser_reg <= {1'b0, |sat_c};
            end
        end
    end

    assign m_tvalid = v_reg[NPIP-1];
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

endmodule

>>> rtl/core/qvr_div_stage.sv
// One restoring-division step for the three rotated components.
module qvr_div_stage (
    input  logic              clk,
    input  logic              en,
    input  qvr_pkg::div_word_t din,
    output qvr_pkg::div_word_t dout
);
    import qvr_pkg::*;

    div_word_t dout_reg;
    div_word_t dout_next;

    always_comb
    begin
        dout_next     = din;
        dout_next.dsh = din.dsh >> 1;
        for (int c = 0; c < 3; c++)
        begin
            if (din.rem[c] >= din.dsh)
            begin
                dout_next.rem[c] = din.rem[c] - din.dsh;
                dout_next.quo[c] = {din.quo[c][QW-2:0], 1'b1};
            end
            else
            begin
                dout_next.quo[c] = {din.quo[c][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

>>> rtl/core/qvr_checker.sv
// Port-level checker for the quaternion vector rotate block, with its bind.
`include "quaternion_vector_rotate_defines.svh"

module qvr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `QVR_ASSERT_NOW(a_degen_zero, clk, rst_n, m_tvalid && m_tuser[1], m_tdata == 48'd0 && !m_tuser[0], "degenerate word with nonzero result")

    `QVR_ASSERT_NOW(a_sat_clamped, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 || m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000 || m_tdata[47:32] == 16'h7fff || m_tdata[47:32] == 16'h8000, "saturated flag without a clamped component")

    `QVR_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready, "input stalled while output is empty")

    `QVR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);
